>>> design/cmos_nvram_port_device_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CMOS / NVRAM port device
// Shared property templates, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CMOS_NVRAM_PORT_DEVICE_ASSERT_SVH
`define CMOS_NVRAM_PORT_DEVICE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CNPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CNPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cnpd_pkg.sv
// ----------------------------------------------------------------------------
// cnpd_pkg
// Constants shared by the CMOS / NVRAM port device modules.
// ----------------------------------------------------------------------------
package cnpd_pkg;

    localparam int NVRAM_DEPTH_DEF = 8192;
    localparam int EXT_W           = 16;
    localparam int CMOS_DEPTH      = 256;

    // port offsets
    localparam logic [3:0] PORT_INDEX0  = 4'd0;
    localparam logic [3:0] PORT_INDEX1  = 4'd1;
    localparam logic [3:0] PORT_DATA2   = 4'd2;
    localparam logic [3:0] PORT_DATA3   = 4'd3;
    localparam logic [3:0] PORT_EXT_LO  = 4'd4;
    localparam logic [3:0] PORT_EXT_HI  = 4'd5;
    localparam logic [3:0] PORT_NVRAM   = 4'd6;
    localparam logic [3:0] PORT_DATA7   = 4'd7;

    // index values with special meaning
    localparam logic [7:0] IDX_COUNTER  = 8'h80;
    localparam logic [7:0] IDX_ALARM    = 8'h0d;
    localparam logic [7:0] IDX_STATUS   = 8'h0a;
    localparam logic [7:0] IDX_RTC_LAST = 8'h0d;

    localparam logic [7:0] VAL_ALARM    = 8'h80;
    localparam logic [7:0] VAL_STATUS   = 8'h40;

    localparam logic [2:0] UPPER_BUMP_REG = 3'd4;
    localparam logic [7:0] UPPER_BUMP_VAL = 8'h35;

endpackage

>>> design/cmos_nvram_port_device.sv
// ----------------------------------------------------------------------------
// cmos_nvram_port_device
// Byte-wide CMOS / NVRAM port block with sixteen port offsets.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive port, mode and wdata and raise start; the beat is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: rdata and rtc_access are valid for exactly one cycle
//   while done is high. The receiver cannot hold results off.
// Result: an accepted beat runs in the execute state, which registers rdata
//   and rtc_access and raises done.
// Flow: busy holds off a new beat until the last one has left the execute
//   state; the CMOS and NVRAM RAMs are read in the accept cycle and written
//   back in the following execute cycle. A write to port 4 or 5 also holds
//   busy in S_MOD until the unit that recomputes the extended index modulo
//   NVRAM_DEPTH (reciprocal multiply, then one correction step) is done.
// Reset: index, extended index and the eight upper registers clear; the
//   CMOS store reads as zero through per-byte valid flags cleared at once,
//   so no clearing pass runs. NVRAM content is undefined until written.
// Special cases: data-port reads of index 10 answer 0x40; others up to 13
//   raise rtc_access and store nothing; writes always return zero data.
// ----------------------------------------------------------------------------
`include "cmos_nvram_port_device_assert.svh"

module cmos_nvram_port_device #(
    parameter int NVRAM_DEPTH = cnpd_pkg::NVRAM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] port,
    input  logic       mode,
    input  logic [7:0] wdata,
    output logic       done,
    output logic [7:0] rdata,
    output logic       rtc_access
);

    localparam int NV_AW = (NVRAM_DEPTH > 1) ? $clog2(NVRAM_DEPTH) : 1;
    localparam int EW    = cnpd_pkg::EXT_W;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MOD} state_t;

    state_t state_reg;
    logic   done_reg;
    logic [7:0] rdata_reg;
    logic   rtc_reg;

    // latched command beat
    logic [3:0] port_reg;
    logic       mode_reg;
    logic [7:0] wdata_reg;

    logic [7:0]    index_reg, index_next;
    logic [EW-1:0] ext_reg, ext_next;
    logic [7:0]    upper_reg [8];
    logic [7:0]    upper_wval;
    logic          upper_we;
    logic [cnpd_pkg::CMOS_DEPTH-1:0] cmos_valid_reg;

    logic       accept;
    logic       exec;
    logic [7:0] cmos_q, cmos_cur, cmos_wd;
    logic       cmos_we;
    logic [7:0] nv_q;
    logic       nv_we;
    logic [7:0] rd_next;
    logic       rtc_next;
    logic       rem_start;
    logic       rem_busy;
    logic [NV_AW-1:0] nv_addr;

    assign accept = start && (state_reg == S_IDLE);
    assign exec   = (state_reg == S_EXEC);
    assign busy   = (state_reg != S_IDLE);

    // unwritten CMOS bytes read as zero
    assign cmos_cur = cmos_valid_reg[index_reg] ? cmos_q : 8'h00;

    cnpd_ram #(
        .WIDTH (8),
        .DEPTH (cnpd_pkg::CMOS_DEPTH)
    ) u_cmos_ram (
        .clk  (clk),
        .en   (accept || exec),
        .we   (cmos_we),
        .addr (index_reg),
        .din  (cmos_wd),
        .dout (cmos_q)
    );

    cnpd_ram #(
        .WIDTH (8),
        .DEPTH (NVRAM_DEPTH)
    ) u_nvram_ram (
        .clk  (clk),
        .en   (accept || exec),
        .we   (nv_we),
        .addr (nv_addr),
        .din  (wdata_reg),
        .dout (nv_q)
    );

    cnpd_remainder #(
        .DEPTH (NVRAM_DEPTH)
    ) u_remainder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_start),
        .value (ext_next),
        .busy  (rem_busy),
        .rem   (nv_addr)
    );

    // Execute: decode the latched beat against the RAM read data and
    // produce the result plus all write-backs.
    always_comb
    begin
        rd_next    = 8'h00;
        rtc_next   = 1'b0;
        index_next = index_reg;
        ext_next   = ext_reg;
        cmos_wd    = wdata_reg;
        cmos_we    = 1'b0;
        nv_we      = 1'b0;
        upper_we   = 1'b0;
        upper_wval = wdata_reg;
        rem_start  = 1'b0;

        case (port_reg)
            cnpd_pkg::PORT_INDEX1:
            begin
                if (mode_reg)
                begin
                    index_next = wdata_reg;
                end
                else if (index_reg == cnpd_pkg::IDX_COUNTER)
                begin
                    // pre-increment the counter byte and return it
                    cmos_wd = cmos_cur + 8'h01;
                    cmos_we = exec;
                    rd_next = cmos_cur + 8'h01;
                end
                else if (index_reg == cnpd_pkg::IDX_ALARM)
                begin
                    rd_next = cnpd_pkg::VAL_ALARM;
                end
                else
                begin
                    rd_next = index_reg;
                end
            end
            cnpd_pkg::PORT_EXT_LO:
            begin
                if (mode_reg)
                begin
                    ext_next  = {ext_reg[EW-1:8], wdata_reg};
                    rem_start = exec;
                end
                else
                begin
                    rd_next = ext_reg[7:0];
                end
            end
            cnpd_pkg::PORT_EXT_HI:
            begin
                if (mode_reg)
                begin
                    ext_next  = {wdata_reg, ext_reg[7:0]};
                    rem_start = exec;
                end
                else
                begin
                    rd_next = ext_reg[EW-1:8];
                end
            end
            cnpd_pkg::PORT_NVRAM:
            begin
                nv_we   = exec && mode_reg;
                rd_next = nv_q;
            end
            cnpd_pkg::PORT_INDEX0, cnpd_pkg::PORT_DATA2,
            cnpd_pkg::PORT_DATA3, cnpd_pkg::PORT_DATA7:
            begin
                if ((port_reg == cnpd_pkg::PORT_INDEX0) && mode_reg)
                begin
                    index_next = wdata_reg;
                end
                else if (index_reg == cnpd_pkg::IDX_STATUS)
                begin
                    rd_next = cnpd_pkg::VAL_STATUS;
                end
                else if (index_reg <= cnpd_pkg::IDX_RTC_LAST)
                begin
                    rtc_next = 1'b1;
                end
                else
                begin
                    cmos_we = exec && mode_reg;
                    rd_next = cmos_cur;
                end
            end
            default:
            begin
                // ports 8 to 15: upper byte registers
                rd_next = upper_reg[port_reg[2:0]];
                if (mode_reg)
                begin
                    upper_we = exec;
                end
                else if (port_reg[2:0] == cnpd_pkg::UPPER_BUMP_REG)
                begin
                    upper_we   = exec;
                    upper_wval = upper_reg[port_reg[2:0]] + cnpd_pkg::UPPER_BUMP_VAL;
                end
            end
        endcase

        // writes never return data
        if (mode_reg)
        begin
            rd_next = 8'h00;
        end
    end

    // sequencer and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            rdata_reg <= 8'h00;
            rtc_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            rtc_reg  <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    done_reg  <= 1'b1;
                    rdata_reg <= rd_next;
                    rtc_reg   <= rtc_next;
                    state_reg <= rem_start ? S_MOD : S_IDLE;
                end
                S_MOD:
                begin
                    // hold off new beats until the NVRAM address settles
                    if (!rem_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg      <= 8'h00;
            ext_reg        <= '0;
            cmos_valid_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                upper_reg[i] <= 8'h00;
            end
        end
        else if (exec)
        begin
            index_reg <= index_next;
            ext_reg   <= ext_next;
            if (cmos_we)
            begin
                cmos_valid_reg[index_reg] <= 1'b1;
            end
            if (upper_we)
            begin
                upper_reg[port_reg[2:0]] <= upper_wval;
            end
        end
    end

    // capture the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            port_reg  <= port;
            mode_reg  <= mode;
            wdata_reg <= wdata;
        end
    end

    assign done       = done_reg;
    assign rdata      = rdata_reg;
    assign rtc_access = rtc_reg;

    `CNPD_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && (state_reg == S_EXEC),
        "accepted beat did not enter execute")
    `CNPD_ASSERT_NOW(a_done_after_exec, clk, rst_n, done, $past(state_reg == S_EXEC),
        "result strobe without an execute cycle")
    `CNPD_ASSERT_NOW(a_rtc_only_with_done, clk, rst_n, rtc_access, done,
        "rtc_access raised outside a result beat")
    `CNPD_ASSERT_NEXT(a_write_zero_data, clk, rst_n, exec && mode_reg, rdata == 8'h00,
        "write beat returned nonzero data")
    `CNPD_ASSERT_NEXT(a_mod_unit_started, clk, rst_n, rem_start, rem_busy,
        "index remainder unit failed to start")

endmodule

>>> design/cnpd_ram.sv
// ----------------------------------------------------------------------------
// cnpd_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cnpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] dout_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= din;
            end
            dout_reg <= mem[addr];
        end
    end

    assign dout = dout_reg;

endmodule

>>> design/cnpd_remainder.sv
// ----------------------------------------------------------------------------
// cnpd_remainder
// Remainder of the 16-bit extended index by the NVRAM depth, registered.
// ----------------------------------------------------------------------------
module cnpd_remainder #(
    parameter int DEPTH = cnpd_pkg::NVRAM_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cnpd_pkg::EXT_W-1:0] value,
    output logic                       busy,
    output logic [AW-1:0]              rem
);

    localparam int EW = cnpd_pkg::EXT_W;
    localparam int PW = 2 * EW + 1;
    localparam int LG = (DEPTH > 1) ? $clog2(DEPTH) : 0;
    localparam int SH = EW + LG;
    localparam logic [EW:0] DIVISOR = (EW+1)'(DEPTH);
    localparam logic [EW:0] RECIP   = (EW+1)'((64'd1 << SH) / DEPTH);

    logic          busy_reg;
    logic [EW-1:0] value_reg;
    logic [EW-1:0] quot_reg;
    logic [AW-1:0] rem_reg;

    logic [PW-1:0] prod;
    logic [EW-1:0] quot_next;
    logic [PW-1:0] back;
    logic [EW:0]   diff;
    logic [AW-1:0] rem_next;

    // quotient estimate, low by at most one
    always_comb
    begin
        prod      = PW'(value) * PW'(RECIP);
        quot_next = EW'(prod >> SH);
    end

    // remainder with one correction step
    always_comb
    begin
        back = PW'(quot_reg) * PW'(DIVISOR);
        diff = {1'b0, value_reg} - back[EW:0];
        if (diff >= DIVISOR)
        begin
            diff = diff - DIVISOR;
        end
        rem_next = diff[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            value_reg <= value;
            quot_reg  <= quot_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS / NVRAM port device testbench
// Drives single byte accesses on the command channel and mirrors the
// device's index, CMOS, extended index, NVRAM and upper registers in a
// scoreboard. Each reply beat is checked field by field against the oldest
// prediction, over a directed opening and three phases of random traffic.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic       MODE_READ   = 1'b0;
    localparam logic       MODE_WRITE  = 1'b1;
    localparam logic [3:0] PORT_UPPER0 = 4'd8;

    // Cycles with no beat on either channel before the run is called hung.
    // The slowest legal gap is an extended-index write behind a long sender
    // pause, far below this.
    localparam int STALL_LIMIT = 2000;
    // Beats per random phase.
    localparam int PHASE_BEATS = 460;
    // Drain time after the last reply: covers the extended-index busy window.
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] rdata;
        logic       rtc_access;
    } reply_t;

    // ------------------------------------------------------------------------
    // Mirror of the device state; predicts one reply per accepted access.
    // ------------------------------------------------------------------------
    class nvram_port_mirror;
        bit [7:0]  index_m;
        bit [7:0]  cmos_m [cnpd_pkg::CMOS_DEPTH];
        bit [15:0] ext_m;
        bit [7:0]  nvram_m [cnpd_pkg::NVRAM_DEPTH_DEF];
        bit        nvram_written [cnpd_pkg::NVRAM_DEPTH_DEF];
        bit [7:0]  upper_m [8];
        reply_t    reply_q [$];
        int        errors;

        function new();
            index_m = '0;
            ext_m   = '0;
            errors  = 0;
            foreach (cmos_m[i]) cmos_m[i] = '0;
            foreach (upper_m[i]) upper_m[i] = '0;
            foreach (nvram_written[i]) nvram_written[i] = 1'b0;
        endfunction

        function int nvram_addr();
            return int'(ext_m) % cnpd_pkg::NVRAM_DEPTH_DEF;
        endfunction

        // True when the NVRAM entry under the extended index holds a value.
        function bit nvram_ready();
            return nvram_written[nvram_addr()];
        endfunction

        function int pending();
            return reply_q.size();
        endfunction

        function void take_access(logic [3:0] p, logic m, logic [7:0] d);
            reply_t   r;
            int       a;
            bit [2:0] u;
            r = '0;
            a = nvram_addr();
            u = p[2:0];
            if (p == cnpd_pkg::PORT_INDEX1)
            begin
                if (m == MODE_WRITE)
                    index_m = d;
                else if (index_m == cnpd_pkg::IDX_COUNTER)
                begin
                    cmos_m[cnpd_pkg::IDX_COUNTER] = cmos_m[cnpd_pkg::IDX_COUNTER] + 8'd1;
                    r.rdata = cmos_m[cnpd_pkg::IDX_COUNTER];
                end
                else if (index_m == cnpd_pkg::IDX_ALARM)
                    r.rdata = cnpd_pkg::VAL_ALARM;
                else
                    r.rdata = index_m;
            end
            else if (p == cnpd_pkg::PORT_INDEX0 && m == MODE_WRITE)
                index_m = d;
            else if (p == cnpd_pkg::PORT_EXT_LO)
            begin
                if (m == MODE_WRITE)
                    ext_m[7:0] = d;
                else
                    r.rdata = ext_m[7:0];
            end
            else if (p == cnpd_pkg::PORT_EXT_HI)
            begin
                if (m == MODE_WRITE)
                    ext_m[15:8] = d;
                else
                    r.rdata = ext_m[15:8];
            end
            else if (p == cnpd_pkg::PORT_NVRAM)
            begin
                if (m == MODE_WRITE)
                begin
                    nvram_m[a]       = d;
                    nvram_written[a] = 1'b1;
                end
                else
                    r.rdata = nvram_m[a];
            end
            else if (p[3])
            begin
                if (m == MODE_WRITE)
                    upper_m[u] = d;
                else
                begin
                    r.rdata = upper_m[u];
                    if (u == cnpd_pkg::UPPER_BUMP_REG)
                        upper_m[u] = upper_m[u] + cnpd_pkg::UPPER_BUMP_VAL;
                end
            end
            else
            begin
                // data ports: status byte, clock delegation, or CMOS store
                if (index_m == cnpd_pkg::IDX_STATUS)
                begin
                    if (m == MODE_READ)
                        r.rdata = cnpd_pkg::VAL_STATUS;
                end
                else if (index_m <= cnpd_pkg::IDX_RTC_LAST)
                    r.rtc_access = 1'b1;
                else if (m == MODE_WRITE)
                    cmos_m[index_m] = d;
                else
                    r.rdata = cmos_m[index_m];
            end
            if (m == MODE_WRITE)
                r.rdata = '0;
            reply_q.push_back(r);
        endfunction

        function void check_reply(logic [7:0] rd, logic rtc);
            reply_t e;
            if (reply_q.size() == 0)
            begin
                $error("reply beat with no access waiting: rdata %0h rtc_access %0b",
                       rd, rtc);
                errors++;
                return;
            end
            e = reply_q.pop_front();
            if (rd !== e.rdata)
            begin
                $error("rdata mismatch: expected %0h, actual %0h", e.rdata, rd);
                errors++;
            end
            if (rtc !== e.rtc_access)
            begin
                $error("rtc_access mismatch: expected %0b, actual %0b",
                       e.rtc_access, rtc);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and device signals
    // ------------------------------------------------------------------------
    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [3:0] port  = '0;
    logic       mode  = 1'b0;
    logic [7:0] wdata = '0;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       rtc_access;

    nvram_port_mirror mirror = new();

    // Percentage of cycles in which the sender holds back a beat.
    int idle_pct   = 0;
    int stall_cnt  = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cmos_nvram_port_device #(
        .NVRAM_DEPTH (cnpd_pkg::NVRAM_DEPTH_DEF)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .port       (port),
        .mode       (mode),
        .wdata      (wdata),
        .done       (done),
        .rdata      (rdata),
        .rtc_access (rtc_access)
    );

    // ------------------------------------------------------------------------
    // Reply monitor: the receiver cannot stall, so check every done beat.
    // Signals are read right after the edge, i.e. their pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_reply(rdata, rtc_access);
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no beat on either channel.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cnt = 0;
        else
            stall_cnt = stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("cmos_nvram_port_device test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------

    // Offer one beat, idling first at the current rate; hold it until taken,
    // then record it in the mirror. Start stays high on return so that a
    // following beat can go back to back without a low pulse.
    task automatic send_beat(input logic [3:0] p, input logic m, input logic [7:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        port  <= p;
        mode  <= m;
        wdata <= d;
        do
            @(posedge clk);
        while (!(start && !busy));
        mirror.take_access(p, m, d);
    endtask

    // Index byte biased toward the values the index and data ports treat specially.
    function automatic logic [7:0] pick_index();
        case ($urandom_range(7))
            0:       return cnpd_pkg::IDX_STATUS;
            1:       return cnpd_pkg::IDX_ALARM;
            2:       return cnpd_pkg::IDX_COUNTER;
            3:       return 8'($urandom_range(cnpd_pkg::IDX_RTC_LAST));
            4:       return cnpd_pkg::IDX_RTC_LAST + 8'd1;
            5:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Extended index bytes drawn from a small pool so NVRAM entries get
    // revisited; the high byte's top bits vary to exercise the wrap.
    function automatic logic [7:0] pick_ext_byte(input logic hi);
        logic [4:0] low5;
        case ($urandom_range(3))
            0:       low5 = 5'h00;
            1:       low5 = 5'h01;
            2:       low5 = 5'h1F;
            default: low5 = 5'($urandom);
        endcase
        if (hi)
            return {3'($urandom_range(7)), low5};
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_beat();
        int         pick;
        logic [3:0] p;
        logic       m;
        logic [7:0] d;
        pick = $urandom_range(99);
        m    = 1'($urandom_range(1));
        d    = 8'($urandom);
        if (pick < 18)
        begin
            // load the index through either index port
            p = $urandom_range(1) ? cnpd_pkg::PORT_INDEX1 : cnpd_pkg::PORT_INDEX0;
            m = MODE_WRITE;
            d = pick_index();
        end
        else if (pick < 28)
        begin
            p = cnpd_pkg::PORT_INDEX1;
            m = MODE_READ;
        end
        else if (pick < 55)
        begin
            case ($urandom_range(3))
                0:       p = cnpd_pkg::PORT_INDEX0;
                1:       p = cnpd_pkg::PORT_DATA2;
                2:       p = cnpd_pkg::PORT_DATA3;
                default: p = cnpd_pkg::PORT_DATA7;
            endcase
            // port 0 acts as a data port only on reads
            if (p == cnpd_pkg::PORT_INDEX0)
                m = MODE_READ;
        end
        else if (pick < 63)
        begin
            p = $urandom_range(1) ? cnpd_pkg::PORT_EXT_HI : cnpd_pkg::PORT_EXT_LO;
            m = MODE_WRITE;
            d = pick_ext_byte(p == cnpd_pkg::PORT_EXT_HI);
        end
        else if (pick < 68)
        begin
            p = $urandom_range(1) ? cnpd_pkg::PORT_EXT_HI : cnpd_pkg::PORT_EXT_LO;
            m = MODE_READ;
        end
        else if (pick < 82)
        begin
            // never read an NVRAM entry that has not been written
            p = cnpd_pkg::PORT_NVRAM;
            if (!mirror.nvram_ready())
                m = MODE_WRITE;
        end
        else
            p = PORT_UPPER0 | 4'($urandom_range(7));
        send_beat(p, m, d);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, status byte, alarm index, counter byte,
        // clock delegation (index 13 included), CMOS store, NVRAM at the
        // top of the extended index, upper registers and the bump register.
        idle_pct = 0;
        send_beat(cnpd_pkg::PORT_INDEX1, MODE_READ,  8'hFF);
        send_beat(cnpd_pkg::PORT_INDEX0, MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_INDEX0, MODE_WRITE, cnpd_pkg::IDX_STATUS);
        send_beat(cnpd_pkg::PORT_DATA2,  MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_DATA3,  MODE_WRITE, 8'hFF);
        send_beat(cnpd_pkg::PORT_INDEX1, MODE_WRITE, cnpd_pkg::IDX_ALARM);
        send_beat(cnpd_pkg::PORT_INDEX1, MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_DATA7,  MODE_WRITE, 8'h3C);
        send_beat(cnpd_pkg::PORT_INDEX0, MODE_WRITE, cnpd_pkg::IDX_COUNTER);
        send_beat(cnpd_pkg::PORT_INDEX1, MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_INDEX1, MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_DATA2,  MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_INDEX0, MODE_WRITE, 8'hFF);
        send_beat(cnpd_pkg::PORT_DATA3,  MODE_WRITE, 8'hA5);
        send_beat(cnpd_pkg::PORT_DATA7,  MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_INDEX1, MODE_WRITE, cnpd_pkg::IDX_RTC_LAST + 8'd1);
        send_beat(cnpd_pkg::PORT_INDEX0, MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_EXT_LO, MODE_WRITE, 8'hFF);
        send_beat(cnpd_pkg::PORT_EXT_HI, MODE_WRITE, 8'hFF);
        send_beat(cnpd_pkg::PORT_NVRAM,  MODE_WRITE, 8'h5A);
        send_beat(cnpd_pkg::PORT_NVRAM,  MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_EXT_LO, MODE_READ,  8'h00);
        send_beat(cnpd_pkg::PORT_EXT_HI, MODE_READ,  8'h00);
        send_beat(PORT_UPPER0, MODE_WRITE, 8'hFF);
        send_beat(PORT_UPPER0, MODE_READ,  8'h00);
        send_beat(PORT_UPPER0 | 4'(cnpd_pkg::UPPER_BUMP_REG), MODE_READ, 8'h00);
        send_beat(PORT_UPPER0 | 4'(cnpd_pkg::UPPER_BUMP_REG), MODE_READ, 8'h00);

        // Random phases: light sender idling, heavy idling, then none.
        idle_pct = 36;
        repeat (PHASE_BEATS) random_beat();
        idle_pct = 63;
        repeat (PHASE_BEATS) random_beat();
        idle_pct = 0;
        repeat (PHASE_BEATS) random_beat();

        // Drop start and drain the outstanding replies.
        start <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mirror.pending() != 0)
        begin
            $error("%0d predicted replies never arrived", mirror.pending());
            mirror.errors++;
        end
        if (mirror.errors == 0)
            $display("cmos_nvram_port_device test passed");
        else
            $display("cmos_nvram_port_device test failed");
        $finish;
    end

endmodule
